// ===== sv/scpc_pkg.sv =====
// ----------------------------------------------------------------------------
// scpc_pkg: shared types and constants
// Widths, framing constants and the controller/datapath interface structs
// for the stepper command parser and pulse control unit.
// ----------------------------------------------------------------------------
package scpc_pkg;

  localparam int unsigned CMD_BYTES   = 6;
  localparam int unsigned MAX_CMDS    = 4;
  localparam int unsigned STORE_DEPTH = 1 + MAX_CMDS * CMD_BYTES;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned BYTE_IDX_W  = $clog2(CMD_BYTES);
  localparam int unsigned CMD_IDX_W   = $clog2(MAX_CMDS);
  localparam int unsigned NUM_W       = $clog2(MAX_CMDS + 1);

  localparam int unsigned CLK_HZ_W    = 27;
  localparam int unsigned MASK_W      = 4;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned CMP_W       = 15;
  localparam int unsigned STEPS_W     = 16;
  localparam int unsigned SPEED_W     = 16;
  localparam int unsigned DEN_W       = 20;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned IN_DATA_W   = 16;
  localparam int unsigned OUT_DATA_W  = 56;

  localparam logic [CLK_HZ_W-1:0] CLK_HZ_RESET = 27'd1000000;
  localparam logic [MASK_W-1:0]   MASK_RESET   = 4'd10;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'hFFFF;
  localparam logic [CLK_HZ_W-1:0] PERIOD_MIN   = 27'd3;
  localparam logic [CLK_HZ_W-1:0] PERIOD_MAX   = 27'd65535;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_PULSE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_CLOCK = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_MASK  = 8'd1;

  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_HALT_REL,
    MOP_STOP,
    MOP_START,
    MOP_PULSE
  } mop_e;

  typedef struct packed {
    logic take;
    logic rd_en;
    logic cmd_clr;
    logic cmd_inc;
    logic byte_clr;
    logic byte_inc;
    logic load_id;
    logic mark_valid;
    mop_e mop;
    logic div_start;
    logic emit;
    logic emit_settle;
    logic emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_pulse;
    logic pkt_end;
    logic m_ok;
    logic last_cmd;
    logic last_byte;
    logic hit_last_valid;
    logic speed_zero;
    logic div_done;
    logic pulse_ok;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/scpc_div.sv =====
// ----------------------------------------------------------------------------
// scpc_div: radix-2 restoring divider
// One quotient bit per cycle; done stays high until the next start.
// ----------------------------------------------------------------------------
module scpc_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [scpc_pkg::CLK_HZ_W-1:0]      num_i,
  input  logic [scpc_pkg::DEN_W-1:0]         den_i,
  output logic                               done_o,
  output logic [scpc_pkg::CLK_HZ_W-1:0]      quo_o
);

  localparam int unsigned CNT_W = $clog2(scpc_pkg::CLK_HZ_W);

  logic [scpc_pkg::DEN_W-1:0]    rem_q, rem_d;
  logic [scpc_pkg::CLK_HZ_W-1:0] quo_q, quo_d;
  logic [scpc_pkg::DEN_W-1:0]    den_q;
  logic [CNT_W-1:0]              cnt_q;
  logic                          busy_q, done_q;
  logic [scpc_pkg::DEN_W:0]      trial;
  logic                          fits;

  always_comb begin
    trial = {rem_q, quo_q[scpc_pkg::CLK_HZ_W-1]};
    fits  = trial >= {1'b0, den_q};
    rem_d = fits ? scpc_pkg::DEN_W'(trial - {1'b0, den_q})
                 : trial[scpc_pkg::DEN_W-1:0];
    quo_d = {quo_q[scpc_pkg::CLK_HZ_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(scpc_pkg::CLK_HZ_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== sv/scpc_dp.sv =====
// ----------------------------------------------------------------------------
// scpc_dp: datapath
// Config registers, packet framing and store, per-motor state, period
// divider and the output register.
// ----------------------------------------------------------------------------
module scpc_dp #(
  parameter int MOTOR_COUNT = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [scpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [scpc_pkg::CLK_HZ_W-1:0]       cfg_data_i,
  input  logic [scpc_pkg::IN_DATA_W-1:0]      in_data_i,
  input  logic                                in_user_i,
  input  scpc_pkg::ctrl_cmd_t                 cmd_i,
  output scpc_pkg::dp_status_t                status_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [scpc_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic                                out_last_o
);

  localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int AW     = scpc_pkg::ADDR_W;

  logic [scpc_pkg::CLK_HZ_W-1:0] clk_hz_q;
  logic [scpc_pkg::MASK_W-1:0]   mask_q;

  logic [7:0]                        store [scpc_pkg::STORE_DEPTH];
  logic [7:0]                        fld_q [scpc_pkg::CMD_BYTES];
  logic [AW-1:0]                     bc_q, exp_q;
  logic [scpc_pkg::NUM_W-1:0]        num_q;
  logic [scpc_pkg::CMD_IDX_W-1:0]    cmd_q, last_valid_q;
  logic [scpc_pkg::BYTE_IDX_W-1:0]   byte_q;
  logic [MIDX_W-1:0]                 m_q;
  logic                              m_ok_q;

  logic                              run_q   [MOTOR_COUNT];
  logic                              dir_q   [MOTOR_COUNT];
  logic [scpc_pkg::PERIOD_W-1:0]     per_q   [MOTOR_COUNT];
  logic [scpc_pkg::STEPS_W-1:0]      steps_q [MOTOR_COUNT];
  logic                              brk_q   [MOTOR_COUNT];

  logic                              ov_q;
  logic [scpc_pkg::OUT_DATA_W-1:0]   od_q;
  logic                              ol_q;

  logic [7:0]                        byte_in;
  logic [1:0]                        pulse_motor;
  logic                              byte_take, pulse_take;
  logic [AW-1:0]                     wr_idx, bc_inc, exp_new, rd_addr, c5, b5;
  logic                              cnt_ok;
  logic [31:0]                       id_ext, id_m, pm_ext, m_ext;
  logic                              hb;
  logic [scpc_pkg::SPEED_W-1:0]      speed;
  logic [scpc_pkg::DEN_W-1:0]        sp20, den;
  logic                              div_done;
  logic [scpc_pkg::CLK_HZ_W-1:0]     quo, qm1;
  logic [scpc_pkg::PERIOD_W-1:0]     period_new;
  logic [scpc_pkg::STEPS_W-1:0]      steps_dec;

  assign byte_in     = in_data_i[7:0];
  assign pulse_motor = in_data_i[9:8];
  assign byte_take   = cmd_i.take && (in_user_i == scpc_pkg::OP_BYTE);
  assign pulse_take  = cmd_i.take && (in_user_i == scpc_pkg::OP_PULSE);

  // packet framing
  always_comb begin
    wr_idx  = (bc_q >= AW'(scpc_pkg::STORE_DEPTH)) ? '0 : bc_q;
    bc_inc  = wr_idx + AW'(1);
    cnt_ok  = (byte_in >= 8'd1) && (byte_in <= 8'(scpc_pkg::MAX_CMDS));
    b5      = AW'(byte_in[2:0]);
    exp_new = (b5 << 2) + (b5 << 1) + AW'(1);
    c5      = AW'(cmd_q);
    rd_addr = (c5 << 2) + (c5 << 1) + AW'(1) + AW'(byte_q);
  end

  always_ff @(posedge clk_i) begin
    if (byte_take) begin
      store[wr_idx] <= byte_in;
    end
    if (cmd_i.rd_en) begin
      fld_q[byte_q] <= store[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= scpc_pkg::CLK_HZ_RESET;
      mask_q   <= scpc_pkg::MASK_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        scpc_pkg::CFG_TIMER_CLOCK: clk_hz_q <= cfg_data_i;
        scpc_pkg::CFG_BRAKE_MASK:  mask_q   <= cfg_data_i[scpc_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q  <= '0;
      exp_q <= '0;
      num_q <= '0;
    end else if (byte_take) begin
      if (bc_inc == AW'(1)) begin
        if (cnt_ok) begin
          bc_q  <= AW'(1);
          exp_q <= exp_new;
          num_q <= scpc_pkg::NUM_W'(byte_in[2:0]);
        end else begin
          bc_q <= '0;
        end
      end else if (bc_inc == exp_q) begin
        bc_q  <= '0;
        exp_q <= '0;
      end else begin
        bc_q <= bc_inc;
      end
    end
  end

  // command and byte counters, motor select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q        <= '0;
      byte_q       <= '0;
      last_valid_q <= '0;
      m_q          <= '0;
      m_ok_q       <= 1'b0;
    end else begin
      if (cmd_i.cmd_clr) begin
        cmd_q <= '0;
      end else if (cmd_i.cmd_inc) begin
        cmd_q <= cmd_q + scpc_pkg::CMD_IDX_W'(1);
      end
      if (cmd_i.byte_clr) begin
        byte_q <= '0;
      end else if (cmd_i.byte_inc) begin
        byte_q <= byte_q + scpc_pkg::BYTE_IDX_W'(1);
      end
      if (cmd_i.mark_valid) begin
        last_valid_q <= cmd_q;
      end
      if (pulse_take) begin
        m_ok_q <= pm_ext < 32'(MOTOR_COUNT);
        m_q    <= pm_ext[MIDX_W-1:0];
      end else if (cmd_i.load_id) begin
        m_ok_q <= (id_ext >= 32'd1) && (id_ext <= 32'(MOTOR_COUNT));
        m_q    <= id_m[MIDX_W-1:0];
      end
    end
  end

  always_comb begin
    id_ext = 32'(fld_q[0]);
    id_m   = id_ext - 32'd1;
    pm_ext = 32'(pulse_motor);
    m_ext  = 32'(m_q);
    hb     = (m_ext < 32'd4) && mask_q[m_ext[1:0]];
    speed  = {fld_q[2], fld_q[3]};
    sp20   = scpc_pkg::DEN_W'(speed);
    den    = (sp20 << 3) + (sp20 << 1);
  end

  scpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (clk_hz_q),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    qm1 = (quo == '0) ? '0 : quo - scpc_pkg::CLK_HZ_W'(1);
    if (qm1 < scpc_pkg::PERIOD_MIN) begin
      period_new = scpc_pkg::PERIOD_W'(scpc_pkg::PERIOD_MIN);
    end else if (qm1 > scpc_pkg::PERIOD_MAX) begin
      period_new = scpc_pkg::PERIOD_W'(scpc_pkg::PERIOD_MAX);
    end else begin
      period_new = qm1[scpc_pkg::PERIOD_W-1:0];
    end
    steps_dec = steps_q[m_q] - scpc_pkg::STEPS_W'(1);
  end

  // per-motor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        run_q[i]   <= 1'b0;
        dir_q[i]   <= 1'b0;
        per_q[i]   <= scpc_pkg::PERIOD_RESET;
        steps_q[i] <= '0;
        brk_q[i]   <= 1'b0;
      end
    end else begin
      case (cmd_i.mop)
        scpc_pkg::MOP_HALT_REL: begin
          run_q[m_q]   <= 1'b0;
          steps_q[m_q] <= '0;
          if (hb) begin
            brk_q[m_q] <= 1'b1;
          end
        end
        scpc_pkg::MOP_STOP: begin
          run_q[m_q]   <= 1'b0;
          steps_q[m_q] <= '0;
          if (hb) begin
            brk_q[m_q] <= 1'b0;
          end
        end
        scpc_pkg::MOP_START: begin
          run_q[m_q]   <= 1'b1;
          dir_q[m_q]   <= fld_q[1] != 8'd0;
          steps_q[m_q] <= {fld_q[4], fld_q[5]};
          per_q[m_q]   <= period_new;
        end
        scpc_pkg::MOP_PULSE: begin
          steps_q[m_q] <= steps_dec;
          if (steps_dec == '0) begin
            run_q[m_q] <= 1'b0;
            if (hb) begin
              brk_q[m_q] <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      od_q <= {3'b000, cmd_i.emit_settle, steps_q[m_q], brk_q[m_q],
               per_q[m_q][scpc_pkg::PERIOD_W-1:1], per_q[m_q], dir_q[m_q],
               run_q[m_q], m_ext[1:0]};
      ol_q <= cmd_i.emit_last;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign out_last_o  = ol_q;

  always_comb begin
    status_o.is_pulse       = in_user_i == scpc_pkg::OP_PULSE;
    status_o.pkt_end        = byte_take && (bc_inc != AW'(1)) && (bc_inc == exp_q);
    status_o.m_ok           = m_ok_q;
    status_o.last_cmd       = (scpc_pkg::NUM_W'(cmd_q) + scpc_pkg::NUM_W'(1)) == num_q;
    status_o.last_byte      = byte_q == scpc_pkg::BYTE_IDX_W'(scpc_pkg::CMD_BYTES - 1);
    status_o.hit_last_valid = cmd_q == last_valid_q;
    status_o.speed_zero     = speed == '0;
    status_o.div_done       = div_done;
    status_o.pulse_ok       = m_ok_q && run_q[m_q] && (steps_q[m_q] != '0);
    status_o.out_free       = !ov_q || out_ready_i;
  end

endmodule

// ===== sv/scpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// scpc_ctrl: sequencer
// Accepts requests, walks the two packet passes and the pulse update,
// and hands results to the output register.
// ----------------------------------------------------------------------------
module scpc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  scpc_pkg::dp_status_t  status_i,
  output scpc_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PU_CHK,
    S_PU_EMIT,
    S_P1_RD,
    S_P1_CHK,
    S_P1_APPLY,
    S_P1_EMIT,
    S_P2_RD,
    S_P2_CHK,
    S_P2_OP,
    S_P2_DIV,
    S_P2_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   first_q, first_d;

  always_comb begin
    state_d     = state_q;
    first_d     = first_q;
    cmd_o       = '0;
    cmd_o.mop   = scpc_pkg::MOP_NONE;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (status_i.is_pulse) begin
            state_d = S_PU_CHK;
          end else if (status_i.pkt_end) begin
            cmd_o.cmd_clr  = 1'b1;
            cmd_o.byte_clr = 1'b1;
            state_d        = S_P1_RD;
          end
        end
      end
      S_PU_CHK: begin
        if (status_i.pulse_ok) begin
          cmd_o.mop = scpc_pkg::MOP_PULSE;
          state_d   = S_PU_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_PU_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_P1_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_P1_CHK;
      end
      S_P1_CHK: begin
        cmd_o.load_id = 1'b1;
        state_d       = S_P1_APPLY;
      end
      S_P1_APPLY, S_P1_EMIT: begin
        if (state_q == S_P1_APPLY && status_i.m_ok) begin
          cmd_o.mop        = scpc_pkg::MOP_HALT_REL;
          cmd_o.mark_valid = 1'b1;
          state_d          = S_P1_EMIT;
        end else if (state_q == S_P1_APPLY || status_i.out_free) begin
          cmd_o.emit = state_q == S_P1_EMIT;
          if (status_i.last_cmd) begin
            cmd_o.cmd_clr  = 1'b1;
            cmd_o.byte_clr = 1'b1;
            first_d        = 1'b1;
            state_d        = S_P2_RD;
          end else begin
            cmd_o.cmd_inc = 1'b1;
            state_d       = S_P1_RD;
          end
        end
      end
      S_P2_RD: begin
        cmd_o.rd_en = 1'b1;
        if (status_i.last_byte) begin
          cmd_o.byte_clr = 1'b1;
          state_d        = S_P2_CHK;
        end else begin
          cmd_o.byte_inc = 1'b1;
        end
      end
      S_P2_CHK: begin
        cmd_o.load_id = 1'b1;
        state_d       = S_P2_OP;
      end
      S_P2_OP, S_P2_EMIT: begin
        if (state_q == S_P2_OP && status_i.m_ok) begin
          if (status_i.speed_zero) begin
            cmd_o.mop = scpc_pkg::MOP_STOP;
            state_d   = S_P2_EMIT;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_P2_DIV;
          end
        end else if (state_q == S_P2_OP || status_i.out_free) begin
          if (state_q == S_P2_EMIT) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_settle = first_q;
            cmd_o.emit_last   = status_i.hit_last_valid;
            first_d           = 1'b0;
          end
          if (status_i.last_cmd) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.cmd_inc = 1'b1;
            state_d       = S_P2_RD;
          end
        end
      end
      S_P2_DIV: begin
        if (status_i.div_done) begin
          cmd_o.mop = scpc_pkg::MOP_START;
          state_d   = S_P2_EMIT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
    end
  end

endmodule

// ===== sv/stepper_command_parser_pulse_control_unit.sv =====
// ----------------------------------------------------------------------------
// stepper_command_parser_pulse_control_unit: command framing and pulse control
// Frames command bytes into motor packets and tracks per-motor step state.
// ----------------------------------------------------------------------------
// usage
//   s_axis: one request per item; tuser = opcode (0 byte, 1 pulse done),
//   tdata = byte_in then pulse_motor. m_axis: one motor update per beat,
//   tlast on the final update caused by a request. cfg: index 0 timer clock
//   in hz, index 1 brake mask; always ready, write only while idle.
//   a plain command byte is taken while the sequencer stays idle. a pulse
//   request that yields an update walks a check state and an emit state that
//   loads the output register, and the next request is taken once the
//   sequencer is back in idle; a pulse with no update frees the input after
//   the check. a packet end runs two passes over the stored commands: a stop
//   pass over the valid commands, then a command pass in which each started
//   command waits for the period divider (one quotient bit per cycle); the next request is taken after both passes.
//   reset clears framing, motor state (period 65535, brakes engaged) and
//   config to defaults. a stalled m_axis holds the output register; the
//   sequencer then waits at its next update without dropping work.
// ----------------------------------------------------------------------------
module stepper_command_parser_pulse_control_unit #(
  parameter int MOTOR_COUNT = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [scpc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [scpc_pkg::CLK_HZ_W-1:0]     cfg_data_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // byte_in [7:0], pulse_motor [9:8]
  input  logic [scpc_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // opcode [0]
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // motor_index [1:0], running [2], direction [3], period [19:4],
  // compare [34:20], brake_released [35], steps_left [51:36], settle_before [52]
  output logic [scpc_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic                              m_axis_tlast_o
);

  scpc_pkg::ctrl_cmd_t  cmd;
  scpc_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  scpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  scpc_dp #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// ===== sv/scpc_checker.sv =====
// ----------------------------------------------------------------------------
// scpc_checker: port-level checks
// Output stream consistency for the stepper command parser unit.
// ----------------------------------------------------------------------------
module scpc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [scpc_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  input logic                             m_axis_tlast_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output changed while stalled");

  a_compare_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[34:20] == m_axis_tdata_o[19:5])
    else $error("compare is not half of period");

  a_period_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[19:4] >= 16'd3)
    else $error("period below minimum");

  a_stopped_no_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[2] |-> m_axis_tdata_o[51:36] == 16'd0)
    else $error("stopped motor with steps left");

endmodule

bind stepper_command_parser_pulse_control_unit scpc_checker u_scpc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ===== tb/stepper_command_parser_pulse_control_unit_tb.sv =====
// ----------------------------------------------------------------------------
// stepper_command_parser_pulse_control_unit_tb: self-checking testbench
// Streams command bytes and pulse-done events into the unit and predicts
// every motor update from a local model of the framing and motor state. It
// checks each update field by field in order, then sweeps the timer clock and
// brake mask over extreme and random settings. Random idling on both
// streams, a long output hold-off and a drain pause exercise flow control.
// ----------------------------------------------------------------------------
module stepper_command_parser_pulse_control_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MOTOR_COUNT  = 4;
  localparam int IDLE_PCT     = 26;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT  = 4000;
  localparam logic [scpc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 8'd2;

  typedef struct packed {
    logic        settle;
    logic [15:0] steps;
    logic        brake_rel;
    logic [14:0] cmp;
    logic [15:0] period;
    logic        dir;
    logic        running;
    logic [1:0]  motor;
    logic        last;
  } motor_update_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [scpc_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [scpc_pkg::CLK_HZ_W-1:0]   cfg_data_i = '0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [scpc_pkg::IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                            s_axis_tuser_i = 1'b0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [scpc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                            m_axis_tlast_o;

  // local copy of the unit's state
  logic [scpc_pkg::CLK_HZ_W-1:0] timer_hz;
  logic [scpc_pkg::MASK_W-1:0]   brakes;
  logic [7:0]                    frame_store [scpc_pkg::STORE_DEPTH];
  int                            frame_cnt;
  int                            frame_len;
  logic                          mot_run [MOTOR_COUNT];
  logic                          mot_dir [MOTOR_COUNT];
  logic [15:0]                   mot_period [MOTOR_COUNT];
  logic [15:0]                   mot_steps [MOTOR_COUNT];
  logic                          mot_brake_rel [MOTOR_COUNT];

  motor_update_t pending_updates [$];
  motor_update_t seen_update;
  motor_update_t want_update;

  int  errors = 0;
  int  items_sent = 0;
  int  pulses_sent = 0;
  int  packets_done = 0;
  int  cfg_writes = 0;
  int  updates_checked = 0;
  int  stalled_cycles = 0;
  int  hold_requests = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  bit  full_rate = 1'b0;

  stepper_command_parser_pulse_control_unit #(
    .MOTOR_COUNT(MOTOR_COUNT)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  // ------------------------------------------------------------------------
  // motor state model
  // ------------------------------------------------------------------------
  function automatic void reset_motor_model();
    timer_hz = scpc_pkg::CLK_HZ_RESET;
    brakes = scpc_pkg::MASK_RESET;
    frame_cnt = 0;
    frame_len = 0;
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      mot_run[m] = 1'b0;
      mot_dir[m] = 1'b0;
      mot_period[m] = scpc_pkg::PERIOD_RESET;
      mot_steps[m] = '0;
      mot_brake_rel[m] = 1'b0;
    end
  endfunction

  function automatic bit has_brake(input int m);
    return m < scpc_pkg::MASK_W && brakes[m];
  endfunction

  function automatic void queue_update(input int m, input logic settle);
    motor_update_t u;
    u.motor = m[1:0];
    u.running = mot_run[m];
    u.dir = mot_dir[m];
    u.period = mot_period[m];
    u.cmp = mot_period[m][15:1];
    u.brake_rel = mot_brake_rel[m];
    u.steps = mot_steps[m];
    u.settle = settle;
    u.last = 1'b0;
    pending_updates.push_back(u);
  endfunction

  function automatic void halt_motor(input int m);
    mot_run[m] = 1'b0;
    mot_steps[m] = '0;
    if (has_brake(m)) mot_brake_rel[m] = 1'b0;
  endfunction

  function automatic void execute_packet();
    int          num;
    int          base;
    int          m;
    logic [7:0]  id;
    logic [31:0] spd;
    logic [31:0] q;
    bit          first;
    num = frame_store[0];
    if (num > scpc_pkg::MAX_CMDS) num = scpc_pkg::MAX_CMDS;
    first = 1'b1;
    // stop and release pass
    for (int i = 0; i < num; i++) begin
      id = frame_store[1 + i * scpc_pkg::CMD_BYTES];
      if (id >= 1 && id <= MOTOR_COUNT) begin
        m = id - 1;
        halt_motor(m);
        if (has_brake(m)) mot_brake_rel[m] = 1'b1;
        queue_update(m, 1'b0);
      end
    end
    // command pass
    for (int i = 0; i < num; i++) begin
      base = 1 + i * scpc_pkg::CMD_BYTES;
      id = frame_store[base];
      if (id >= 1 && id <= MOTOR_COUNT) begin
        m = id - 1;
        spd = {16'd0, frame_store[base + 2], frame_store[base + 3]};
        spd = spd * 32'd10;
        if (spd == 0) begin
          halt_motor(m);
        end else begin
          mot_dir[m] = frame_store[base + 1] != 8'd0;
          mot_steps[m] = {frame_store[base + 4], frame_store[base + 5]};
          mot_run[m] = 1'b1;
          q = timer_hz / spd;
          q = (q == 0) ? 32'd0 : q - 32'd1;
          if (q < scpc_pkg::PERIOD_MIN) q = scpc_pkg::PERIOD_MIN;
          if (q > scpc_pkg::PERIOD_MAX) q = scpc_pkg::PERIOD_MAX;
          mot_period[m] = q[15:0];
        end
        queue_update(m, first);
        first = 1'b0;
      end
    end
    packets_done++;
  endfunction

  function automatic void predict_motor_updates(input logic op, input logic [7:0] b,
                                                input logic [1:0] pm);
    int            n_before;
    int            m;
    motor_update_t tail;
    n_before = pending_updates.size();
    if (op == scpc_pkg::OP_BYTE) begin
      if (frame_cnt >= scpc_pkg::STORE_DEPTH) frame_cnt = 0;
      frame_store[frame_cnt] = b;
      frame_cnt++;
      if (frame_cnt == 1) begin
        if (b < 1 || b > scpc_pkg::MAX_CMDS) frame_cnt = 0;
        else frame_len = 1 + b * scpc_pkg::CMD_BYTES;
      end else if (frame_cnt == frame_len) begin
        execute_packet();
        frame_cnt = 0;
        frame_len = 0;
      end
    end else begin
      m = pm;
      if (m < MOTOR_COUNT && mot_run[m] && mot_steps[m] != 0) begin
        mot_steps[m] = mot_steps[m] - 16'd1;
        if (mot_steps[m] == 0) begin
          mot_run[m] = 1'b0;
          if (has_brake(m)) mot_brake_rel[m] = 1'b0;
        end
        queue_update(m, 1'b0);
      end
    end
    if (pending_updates.size() > n_before) begin
      tail = pending_updates.pop_back();
      tail.last = 1'b1;
      pending_updates.push_back(tail);
    end
  endfunction

  // ------------------------------------------------------------------------
  // stimulus side
  // ------------------------------------------------------------------------
  task automatic send_item(input logic op, input logic [7:0] b, input logic [1:0] pm);
    if (!full_rate && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {6'd0, pm, b};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_motor_updates(op, b, pm);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(scpc_pkg::OP_BYTE, b, 2'($urandom_range(0, 3)));
  endtask

  task automatic send_pulse(input logic [1:0] m);
    send_item(scpc_pkg::OP_PULSE, 8'($urandom_range(0, 255)), m);
    pulses_sent++;
  endtask

  task automatic send_command(input logic [7:0] id, input logic [7:0] dir,
                              input logic [15:0] spd, input logic [15:0] stp);
    send_byte(id);
    send_byte(dir);
    send_byte(spd[15:8]);
    send_byte(spd[7:0]);
    send_byte(stp[15:8]);
    send_byte(stp[7:0]);
  endtask

  function automatic logic [1:0] pick_pulse_motor();
    int busy [$];
    for (int m = 0; m < MOTOR_COUNT; m++)
      if (mot_run[m] && mot_steps[m] != 0) busy.push_back(m);
    if (busy.size() > 0 && $urandom_range(0, 99) < 70)
      return 2'(busy[$urandom_range(0, busy.size() - 1)]);
    return 2'($urandom_range(0, 3));
  endfunction

  // a packet with random content; broken ones stop short of the end
  task automatic send_packet(input int ncmd, input bit valid_ids, input bit broken);
    logic [7:0] pkt [scpc_pkg::STORE_DEPTH];
    int         len;
    int         cut;
    int         r;
    int         base;
    while (frame_cnt != 0) send_byte(8'($urandom_range(0, 255)));
    pkt[0] = 8'(ncmd);
    for (int c = 0; c < ncmd; c++) begin
      base = 1 + c * scpc_pkg::CMD_BYTES;
      r = $urandom_range(0, 99);
      if (valid_ids || r < 85) pkt[base] = 8'($urandom_range(1, MOTOR_COUNT));
      else if (r < 90) pkt[base] = 8'd0;
      else if (r < 95) pkt[base] = 8'(MOTOR_COUNT + 1);
      else pkt[base] = 8'($urandom_range(0, 255));
      pkt[base + 1] = ($urandom_range(0, 99) < 30) ? 8'd0 : 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 15) {pkt[base + 2], pkt[base + 3]} = 16'd0;
      else if (r < 45) {pkt[base + 2], pkt[base + 3]} = 16'($urandom_range(1, 50));
      else if (r < 55) {pkt[base + 2], pkt[base + 3]} = 16'hFFFF;
      else {pkt[base + 2], pkt[base + 3]} = 16'($urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      if (r < 10) {pkt[base + 4], pkt[base + 5]} = 16'd0;
      else if (r < 70) {pkt[base + 4], pkt[base + 5]} = 16'($urandom_range(1, 4));
      else {pkt[base + 4], pkt[base + 5]} = 16'($urandom_range(0, 65535));
    end
    len = 1 + ncmd * scpc_pkg::CMD_BYTES;
    cut = broken ? $urandom_range(1, len - 1) : len;
    for (int k = 0; k < cut; k++) send_byte(pkt[k]);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [scpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [scpc_pkg::CLK_HZ_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == scpc_pkg::CFG_TIMER_CLOCK) timer_hz = data;
    else if (idx == scpc_pkg::CFG_BRAKE_MASK) brakes = data[scpc_pkg::MASK_W-1:0];
    cfg_writes++;
  endtask

  task automatic apply_settings(input logic [scpc_pkg::CLK_HZ_W-1:0] hz,
                                input logic [scpc_pkg::MASK_W-1:0] mask);
    wait_drained();
    cfg_write(scpc_pkg::CFG_TIMER_CLOCK, hz);
    cfg_write(scpc_pkg::CFG_BRAKE_MASK, {23'($urandom_range(0, 32'h7FFFFF)), mask});
    cfg_valid_i <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------
  task automatic test_count_byte_framing();
    send_byte(8'd0);
    send_byte(8'(scpc_pkg::MAX_CMDS + 1));
    send_byte(8'hFF);
  endtask

  task automatic test_single_motor_run_to_stop();
    send_byte(8'd1);
    send_command(8'(MOTOR_COUNT), 8'h80, 16'h0001, 16'd2);
    send_pulse(2'(MOTOR_COUNT - 1));
    send_pulse(2'(MOTOR_COUNT - 1));
    send_pulse(2'(MOTOR_COUNT - 1));
  endtask

  task automatic test_invalid_id_and_endless_run();
    send_byte(8'd2);
    send_command(8'd0, 8'h01, 16'd100, 16'd5);
    send_command(8'd1, 8'h00, 16'hFFFF, 16'd0);
    send_pulse(2'd0);
  endtask

  task automatic test_mixed_traffic(input int n_items);
    int stop_at;
    int r;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_packet($urandom_range(1, scpc_pkg::MAX_CMDS), 1'b0, 1'b0);
      end else if (r < 78) begin
        repeat ($urandom_range(1, 6)) send_pulse(pick_pulse_motor());
      end else if (r < 90) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_packet($urandom_range(1, scpc_pkg::MAX_CMDS), 1'b0, 1'b1);
      end
    end
  endtask

  task automatic test_settings_sweep();
    apply_settings(27'd1000, 4'h0);
    test_mixed_traffic(50);
    apply_settings(27'd100000000, 4'hF);
    test_mixed_traffic(50);
    apply_settings(27'($urandom_range(1000, 100000000)), 4'($urandom_range(0, 15)));
    wait_drained();
    cfg_write(CFG_UNUSED_INDEX, 27'($urandom_range(0, 32'h7FFFFFF)));
    cfg_valid_i <= 1'b0;
    test_mixed_traffic(50);
    apply_settings(scpc_pkg::CLK_HZ_RESET, scpc_pkg::MASK_RESET);
    test_mixed_traffic(50);
  endtask

  task automatic test_output_backpressure();
    hold_requests <= hold_requests + 1;
    send_packet(scpc_pkg::MAX_CMDS, 1'b1, 1'b0);
    send_packet(scpc_pkg::MAX_CMDS, 1'b1, 1'b0);
    repeat (10) send_pulse(pick_pulse_motor());
  endtask

  task automatic test_pause_until_drained();
    send_packet(2, 1'b1, 1'b0);
    wait_drained();
    repeat (6) send_pulse(pick_pulse_motor());
  endtask

  task automatic test_full_rate_stretch();
    full_rate <= 1'b1;
    test_mixed_traffic(50);
    full_rate <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // result side
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (full_rate) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen_update = {m_axis_tdata_o[52:0], m_axis_tlast_o};
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected motor update, expected none actual %h", $time,
                 seen_update);
        errors++;
      end else begin
        want_update = pending_updates.pop_front();
        check_field("motor_index", 16'(want_update.motor), 16'(seen_update.motor));
        check_field("running", 16'(want_update.running), 16'(seen_update.running));
        check_field("direction", 16'(want_update.dir), 16'(seen_update.dir));
        check_field("period", want_update.period, seen_update.period);
        check_field("compare", 16'(want_update.cmp), 16'(seen_update.cmp));
        check_field("brake_released", 16'(want_update.brake_rel),
                    16'(seen_update.brake_rel));
        check_field("steps_left", want_update.steps, seen_update.steps);
        check_field("settle_before", 16'(want_update.settle), 16'(seen_update.settle));
        check_field("last", 16'(want_update.last), 16'(seen_update.last));
        updates_checked++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout with %0d updates outstanding", $time, pending_updates.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    reset_motor_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_count_byte_framing();
    test_single_motor_run_to_stop();
    test_invalid_id_and_endless_run();
    test_mixed_traffic(90);
    test_output_backpressure();
    test_pause_until_drained();
    test_full_rate_stretch();
    test_settings_sweep();
    wait_drained();
    if (pending_updates.size() != 0) begin
      $display("%0t: %0d motor updates never arrived", $time, pending_updates.size());
      errors++;
    end
    $display("covered %0d requests: %0d complete packets, %0d pulse events, %0d cfg writes",
             items_sent, packets_done, pulses_sent, cfg_writes);
    $display("checked %0d motor updates, %0d mismatches", updates_checked, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
